/* src/rwp_pkg.sv */
// Shared types and constants of the RIFF/WAVE PCM16 mono parser.
`timescale 1ns / 1ps
package rwp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [15:0] PCM_BITS     = 16'd16;
  localparam logic [31:0] FMT_BODY_LEN = 32'd16;
  localparam logic [31:0] RATE_RESET   = 32'd22050;

  localparam logic       KIND_SAMPLE = 1'b0;
  localparam logic       KIND_ERROR  = 1'b1;

  localparam logic [1:0] ERR_RIFF     = 2'd0;
  localparam logic [1:0] ERR_WAVE     = 2'd1;
  localparam logic [1:0] ERR_FORMAT   = 2'd2;
  localparam logic [1:0] ERR_CHANNELS = 2'd3;

  localparam int DIV_STEPS = 32;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

endpackage

/* src/riff_wave_pcm16_mono_parser.sv */
// RIFF/WAVE parser that turns PCM16 frames into a mono Q1.15 sample stream.
// Most bytes are taken one per cycle. The byte that ends a frame, and the last
// byte of the data chunk header, each start the shared 32-step divider
// (frame sum / channel count, or data size in samples / channel count). A
// frame's last byte holds the input through the divide and the result load,
// and the last header byte through the divide, before the next request is
// taken; a byte that raises a parse error holds it to load the result register.
// Any byte that carries a result waits longer while an earlier result is still
// held in the output register. A byte with file_start high restarts the parser;
// after the final frame or an error every other byte is taken and ignored.
`timescale 1ns / 1ps
module riff_wave_pcm16_mono_parser #(
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_ready,
  input  logic               file_start,
  input  logic [7:0]         data_byte,
  output logic               result_valid,
  input  logic               result_ready,
  output logic               kind,
  output logic signed [15:0] mono_sample,
  output logic [31:0]        rate_hz,
  output logic               final_frame,
  output logic [1:0]         error_code
);
  import rwp_pkg::*;

  typedef enum logic [8:0] {
    PH_RIFF_TAG   = 9'b000000001,
    PH_RIFF_SIZE  = 9'b000000010,
    PH_WAVE_TAG   = 9'b000000100,
    PH_CHUNK_ID   = 9'b000001000,
    PH_CHUNK_SIZE = 9'b000010000,
    PH_FMT_BODY   = 9'b000100000,
    PH_SKIP       = 9'b001000000,
    PH_DATA       = 9'b010000000,
    PH_IDLE       = 9'b100000000
  } phase_t;

  typedef enum logic [2:0] {
    S_WAIT = 3'b001,
    S_DIV  = 3'b010,
    S_EMIT = 3'b100
  } ctrl_t;

  typedef enum logic {
    OP_FRAMES = 1'b0,
    OP_SAMPLE = 1'b1
  } div_op_t;

  ctrl_t       state, state_next;
  phase_t      phase, phase_next, ph_cur;
  logic [4:0]  byte_count, byte_count_next;
  logic [31:0] shift_word, shift_word_next;
  logic [31:0] chunk_size, chunk_size_next;
  logic [31:0] chunk_tag, chunk_tag_next;
  logic [15:0] channel_count, channel_count_next;
  logic [15:0] bits_per_sample, bits_per_sample_next;
  logic [31:0] rate_store, rate_store_next;
  logic        fmt_seen, fmt_seen_next;
  logic [31:0] frames_left, frames_left_next;
  logic [15:0] channel_index, channel_index_next;
  logic [31:0] frame_sum, frame_sum_next;
  div_op_t     div_op, div_op_next;
  logic        neg, neg_next;
  logic        last4;
  logic [15:0] cc_adj;

  logic        res_kind, res_kind_next;
  logic [15:0] res_mono, res_mono_next;
  logic [31:0] res_rate, res_rate_next;
  logic        res_final, res_final_next;
  logic [1:0]  res_err, res_err_next;

  div_req_t div_req;
  div_rsp_t div_rsp;

  rwp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign byte_ready = (state == S_WAIT);

  always_comb begin
    state_next           = state;
    phase_next           = phase;
    byte_count_next      = byte_count;
    shift_word_next      = shift_word;
    chunk_size_next      = chunk_size;
    chunk_tag_next       = chunk_tag;
    channel_count_next   = channel_count;
    bits_per_sample_next = bits_per_sample;
    rate_store_next      = rate_store;
    fmt_seen_next        = fmt_seen;
    frames_left_next     = frames_left;
    channel_index_next   = channel_index;
    frame_sum_next       = frame_sum;
    div_op_next          = div_op;
    neg_next             = neg;
    res_kind_next        = res_kind;
    res_mono_next        = res_mono;
    res_rate_next        = res_rate;
    res_final_next       = res_final;
    res_err_next         = res_err;
    div_req              = '0;
    last4                = 1'b0;
    cc_adj               = channel_count;
    ph_cur               = phase;

    unique case (state)
      S_WAIT: begin
        if (byte_valid) begin
          if (file_start) begin
            phase_next           = PH_RIFF_TAG;
            byte_count_next      = '0;
            shift_word_next      = '0;
            chunk_size_next      = '0;
            chunk_tag_next       = '0;
            channel_count_next   = 16'd1;
            bits_per_sample_next = PCM_BITS;
            rate_store_next      = RATE_RESET;
            fmt_seen_next        = 1'b0;
            frames_left_next     = '0;
            channel_index_next   = '0;
            frame_sum_next       = '0;
          end
          ph_cur = phase_next;
          if (ph_cur != PH_IDLE) begin
            shift_word_next = {data_byte, shift_word_next[31:8]};
            byte_count_next = byte_count_next + 5'd1;
            last4           = byte_count_next >= 5'd4;
            unique case (ph_cur)
              PH_RIFF_TAG: begin
                if (last4) begin
                  byte_count_next = '0;
                  if (shift_word_next != TAG_RIFF) begin
                    res_kind_next = KIND_ERROR;
                    res_err_next  = ERR_RIFF;
                    phase_next    = PH_IDLE;
                    state_next    = S_EMIT;
                  end else begin
                    phase_next = PH_RIFF_SIZE;
                  end
                end
              end
              PH_RIFF_SIZE: begin
                if (last4) begin
                  byte_count_next = '0;
                  phase_next      = PH_WAVE_TAG;
                end
              end
              PH_WAVE_TAG: begin
                if (last4) begin
                  byte_count_next = '0;
                  if (shift_word_next != TAG_WAVE) begin
                    res_kind_next = KIND_ERROR;
                    res_err_next  = ERR_WAVE;
                    phase_next    = PH_IDLE;
                    state_next    = S_EMIT;
                  end else begin
                    phase_next = PH_CHUNK_ID;
                  end
                end
              end
              PH_CHUNK_ID: begin
                if (last4) begin
                  byte_count_next = '0;
                  chunk_tag_next  = shift_word_next;
                  phase_next      = PH_CHUNK_SIZE;
                end
              end
              PH_CHUNK_SIZE: begin
                if (last4) begin
                  byte_count_next = '0;
                  chunk_size_next = shift_word_next;
                  if (chunk_tag_next == TAG_FMT) begin
                    phase_next = PH_FMT_BODY;
                  end else if (chunk_tag_next == TAG_DATA) begin
                    if (!fmt_seen_next || bits_per_sample_next != PCM_BITS) begin
                      res_kind_next = KIND_ERROR;
                      res_err_next  = ERR_FORMAT;
                      phase_next    = PH_IDLE;
                      state_next    = S_EMIT;
                    end else begin
                      cc_adj = (channel_count_next == 16'd0) ? 16'd1 : channel_count_next;
                      channel_count_next = cc_adj;
                      if (cc_adj > 16'(MAX_CHANNELS)) begin
                        res_kind_next = KIND_ERROR;
                        res_err_next  = ERR_CHANNELS;
                        phase_next    = PH_IDLE;
                        state_next    = S_EMIT;
                      end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = {1'b0, shift_word_next[31:1]};
                        div_req.divisor  = cc_adj;
                        div_op_next        = OP_FRAMES;
                        channel_index_next = '0;
                        frame_sum_next     = '0;
                        state_next         = S_DIV;
                      end
                    end
                  end else begin
                    phase_next = (shift_word_next == 32'd0) ? PH_CHUNK_ID : PH_SKIP;
                  end
                end
              end
              PH_FMT_BODY: begin
                if (byte_count_next == 5'd4) begin
                  channel_count_next = shift_word_next[31:16];
                end
                if (byte_count_next == 5'd8) begin
                  rate_store_next = shift_word_next;
                end
                if (byte_count_next >= 5'd16) begin
                  bits_per_sample_next = shift_word_next[31:16];
                  fmt_seen_next        = 1'b1;
                  byte_count_next      = '0;
                  if (chunk_size_next > FMT_BODY_LEN) begin
                    chunk_size_next = chunk_size_next - FMT_BODY_LEN;
                    phase_next      = PH_SKIP;
                  end else begin
                    phase_next = PH_CHUNK_ID;
                  end
                end
              end
              PH_SKIP: begin
                byte_count_next = '0;
                chunk_size_next = chunk_size_next - 32'd1;
                if (chunk_size_next == 32'd0) begin
                  phase_next = PH_CHUNK_ID;
                end
              end
              PH_DATA: begin
                if (byte_count_next >= 5'd2) begin
                  byte_count_next = '0;
                  frame_sum_next = frame_sum_next
                                 + {{16{shift_word_next[31]}}, shift_word_next[31:16]};
                  channel_index_next = channel_index_next + 16'd1;
                  if (channel_index_next >= channel_count_next) begin
                    frames_left_next = frames_left_next - 32'd1;
                    neg_next         = frame_sum_next[31];
                    div_req.start    = 1'b1;
                    div_req.dividend = frame_sum_next[31] ? (32'd0 - frame_sum_next)
                                                          : frame_sum_next;
                    div_req.divisor  = channel_count_next;
                    div_op_next      = OP_SAMPLE;
                    res_kind_next    = KIND_SAMPLE;
                    res_rate_next    = rate_store_next;
                    res_err_next     = ERR_RIFF;
                    res_final_next   = (frames_left_next == 32'd0);
                    if (frames_left_next == 32'd0) begin
                      phase_next = PH_IDLE;
                    end
                    frame_sum_next     = '0;
                    channel_index_next = '0;
                    state_next         = S_DIV;
                  end
                end
              end
              default: begin
              end
            endcase
            if (res_kind_next == KIND_ERROR && state_next == S_EMIT) begin
              res_mono_next  = '0;
              res_rate_next  = '0;
              res_final_next = 1'b0;
            end
          end
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (div_op == OP_FRAMES) begin
            frames_left_next = div_rsp.quotient;
            phase_next = (div_rsp.quotient == 32'd0) ? PH_IDLE : PH_DATA;
            state_next = S_WAIT;
          end else begin
            res_mono_next = neg ? (16'd0 - div_rsp.quotient[15:0]) : div_rsp.quotient[15:0];
            state_next    = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (!result_valid || result_ready) begin
          state_next = S_WAIT;
        end
      end
      default: begin
        state_next = S_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_WAIT;
      phase           <= PH_RIFF_TAG;
      byte_count      <= '0;
      shift_word      <= '0;
      chunk_size      <= '0;
      chunk_tag       <= '0;
      channel_count   <= 16'd1;
      bits_per_sample <= PCM_BITS;
      rate_store      <= RATE_RESET;
      fmt_seen        <= 1'b0;
      frames_left     <= '0;
      channel_index   <= '0;
      frame_sum       <= '0;
      div_op          <= OP_FRAMES;
      neg             <= 1'b0;
      result_valid    <= 1'b0;
    end else begin
      state           <= state_next;
      phase           <= phase_next;
      byte_count      <= byte_count_next;
      shift_word      <= shift_word_next;
      chunk_size      <= chunk_size_next;
      chunk_tag       <= chunk_tag_next;
      channel_count   <= channel_count_next;
      bits_per_sample <= bits_per_sample_next;
      rate_store      <= rate_store_next;
      fmt_seen        <= fmt_seen_next;
      frames_left     <= frames_left_next;
      channel_index   <= channel_index_next;
      frame_sum       <= frame_sum_next;
      div_op          <= div_op_next;
      neg             <= neg_next;
      if (state == S_EMIT && (!result_valid || result_ready)) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_kind  <= res_kind_next;
    res_mono  <= res_mono_next;
    res_rate  <= res_rate_next;
    res_final <= res_final_next;
    res_err   <= res_err_next;
    if (state == S_EMIT && (!result_valid || result_ready)) begin
      kind        <= res_kind;
      mono_sample <= res_mono;
      rate_hz     <= res_rate;
      final_frame <= res_final;
      error_code  <= res_err;
    end
  end

`ifndef SYNTH
  a_ready_div_idle: assert property (@(posedge clk) disable iff (rst)
    byte_ready |-> !div_rsp.busy)
    else $error("Request taken while the divider is busy.");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIV)
    else $error("Divider finished outside the divide state.");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == KIND_ERROR |-> mono_sample == 16'sd0 && !final_frame
      && rate_hz == 32'd0)
    else $error("Error result carries sample fields.");

  a_start_leaves_wait: assert property (@(posedge clk) disable iff (rst)
    div_req.start |=> state == S_DIV)
    else $error("Divider started without entering the divide state.");
`endif

endmodule

/* src/rwp_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module rwp_div (
  input  logic              clk,
  input  logic              rst,
  input  rwp_pkg::div_req_t req,
  output rwp_pkg::div_rsp_t rsp
);
  import rwp_pkg::*;

  logic        busy;
  logic        done;
  logic [4:0]  count;
  logic [15:0] rem;
  logic [31:0] quo;
  logic [15:0] dsr;
  logic [16:0] trial;
  logic        fits;
  logic [15:0] rem_next;

  always_comb begin
    trial    = {rem, quo[31]};
    fits     = trial >= {1'b0, dsr};
    rem_next = fits ? 16'(trial - {1'b0, dsr}) : trial[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && count == 5'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      count <= 5'(DIV_STEPS - 1);
      rem   <= '0;
      quo   <= req.dividend;
      dsr   <= req.divisor;
    end else if (busy) begin
      count <= count - 5'd1;
      rem   <= rem_next;
      quo   <= {quo[30:0], fits};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

/* bench/riff_wave_pcm16_mono_parser_test.sv */
// Self-checking testbench that feeds WAV byte streams to the mono parser and checks every result.
`timescale 1ns / 1ps
module riff_wave_pcm16_mono_parser_test;
  import rwp_pkg::*;

  localparam int unsigned MAX_CH       = 8;
  localparam int unsigned LIMIT_CYCLES = 500000;
  localparam int unsigned DRAIN_CYCLES = 100;

  typedef enum logic [3:0] {
    PH_RIFF_TAG, PH_RIFF_SIZE, PH_WAVE_TAG, PH_CHUNK_ID, PH_CHUNK_SIZE,
    PH_FMT_BODY, PH_SKIP, PH_DATA, PH_IDLE
  } wav_phase_e;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] sample;
    logic [31:0]        rate;
    logic               is_final;
    logic [1:0]         code;
  } wav_result_t;

  class wav_parse_tracker;
    wav_phase_e  phase;
    logic [31:0] nbytes, shift, size, tag, rate, frames, sum;
    logic [15:0] chans, bits, chan_idx;
    bit          fmt_ok;
    wav_result_t pending[$];
    int unsigned mismatches;

    function new();
      restart();
      mismatches = 0;
    endfunction

    function void restart();
      phase = PH_RIFF_TAG;
      nbytes = '0;
      shift = '0;
      size = '0;
      tag = '0;
      chans = 16'd1;
      bits = PCM_BITS;
      rate = RATE_RESET;
      fmt_ok = 1'b0;
      frames = '0;
      chan_idx = '0;
      sum = '0;
    endfunction

    function void raise_error(logic [1:0] code);
      wav_result_t r;
      r = '0;
      r.kind = KIND_ERROR;
      r.code = code;
      pending.push_back(r);
      phase = PH_IDLE;
    endfunction

    function void close_header();
      logic [31:0] n;
      if (tag == TAG_FMT) begin
        phase = PH_FMT_BODY;
      end else if (tag == TAG_DATA) begin
        if (!fmt_ok || bits != PCM_BITS) begin
          raise_error(ERR_FORMAT);
        end else begin
          if (chans == 16'd0) chans = 16'd1;
          if (chans > MAX_CH) begin
            raise_error(ERR_CHANNELS);
          end else begin
            n = (size >> 1) / {16'd0, chans};
            frames = n;
            chan_idx = '0;
            sum = '0;
            phase = (n == 32'd0) ? PH_IDLE : PH_DATA;
          end
        end
      end else begin
        phase = (size == 32'd0) ? PH_CHUNK_ID : PH_SKIP;
      end
    endfunction

    function void take_byte(logic fs, logic [7:0] b);
      logic [15:0] s;
      logic [31:0] mag, q;
      wav_result_t r;
      if (fs) restart();
      if (phase == PH_IDLE) return;
      shift = {b, shift[31:8]};
      nbytes = nbytes + 32'd1;
      case (phase)
        PH_RIFF_TAG: if (nbytes >= 32'd4) begin
          nbytes = '0;
          if (shift != TAG_RIFF) raise_error(ERR_RIFF);
          else phase = PH_RIFF_SIZE;
        end
        PH_RIFF_SIZE: if (nbytes >= 32'd4) begin
          nbytes = '0;
          phase = PH_WAVE_TAG;
        end
        PH_WAVE_TAG: if (nbytes >= 32'd4) begin
          nbytes = '0;
          if (shift != TAG_WAVE) raise_error(ERR_WAVE);
          else phase = PH_CHUNK_ID;
        end
        PH_CHUNK_ID: if (nbytes >= 32'd4) begin
          nbytes = '0;
          tag = shift;
          phase = PH_CHUNK_SIZE;
        end
        PH_CHUNK_SIZE: if (nbytes >= 32'd4) begin
          nbytes = '0;
          size = shift;
          close_header();
        end
        PH_FMT_BODY: begin
          if (nbytes == 32'd4) chans = shift[31:16];
          if (nbytes == 32'd8) rate = shift;
          if (nbytes >= FMT_BODY_LEN) begin
            bits = shift[31:16];
            fmt_ok = 1'b1;
            nbytes = '0;
            if (size > FMT_BODY_LEN) begin
              size = size - FMT_BODY_LEN;
              phase = PH_SKIP;
            end else begin
              phase = PH_CHUNK_ID;
            end
          end
        end
        PH_SKIP: begin
          nbytes = '0;
          size = size - 32'd1;
          if (size == 32'd0) phase = PH_CHUNK_ID;
        end
        PH_DATA: if (nbytes >= 32'd2) begin
          nbytes = '0;
          s = shift[31:16];
          sum = sum + {{16{s[15]}}, s};
          chan_idx = chan_idx + 16'd1;
          if (chan_idx >= chans) begin
            mag = sum[31] ? (32'd0 - sum) : sum;
            q = mag / {16'd0, chans};
            if (sum[31]) q = 32'd0 - q;
            frames = frames - 32'd1;
            r = '0;
            r.kind = KIND_SAMPLE;
            r.sample = q[15:0];
            r.rate = rate;
            r.is_final = (frames == 32'd0);
            pending.push_back(r);
            if (frames == 32'd0) phase = PH_IDLE;
            sum = '0;
            chan_idx = '0;
          end
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      mismatches++;
      $display("ERROR: %s", msg);
    endtask

    task match_result(wav_result_t got);
      wav_result_t e;
      if (pending.size() == 0) begin
        report("result arrived with no request pending");
        return;
      end
      e = pending.pop_front();
      if (got.kind != e.kind)
        report($sformatf("kind got %0d expected %0d", got.kind, e.kind));
      if (got.sample != e.sample)
        report($sformatf("mono_sample got %0d expected %0d", got.sample, e.sample));
      if (got.rate != e.rate)
        report($sformatf("rate_hz got %0d expected %0d", got.rate, e.rate));
      if (got.is_final != e.is_final)
        report($sformatf("final_frame got %0d expected %0d", got.is_final, e.is_final));
      if (got.code != e.code)
        report($sformatf("error_code got %0d expected %0d", got.code, e.code));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               byte_valid;
  logic               byte_ready;
  logic               file_start;
  logic [7:0]         data_byte;
  logic               result_valid;
  logic               result_ready;
  logic               kind;
  logic signed [15:0] mono_sample;
  logic [31:0]        rate_hz;
  logic               final_frame;
  logic [1:0]         error_code;

  wav_parse_tracker tracker;
  logic [7:0]       file_bytes[$];
  int unsigned      send_idle;
  int unsigned      recv_idle;
  int unsigned      cycle_count = 0;

  riff_wave_pcm16_mono_parser #(
    .MAX_CHANNELS(MAX_CH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .file_start(file_start),
    .data_byte(data_byte),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .kind(kind),
    .mono_sample(mono_sample),
    .rate_hz(rate_hz),
    .final_frame(final_frame),
    .error_code(error_code)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    wav_result_t got;
    if (!rst && result_valid && result_ready) begin
      got.kind = kind;
      got.sample = mono_sample;
      got.rate = rate_hz;
      got.is_final = final_frame;
      got.code = error_code;
      tracker.match_result(got);
    end
    result_ready <= ($urandom_range(99) >= recv_idle);
  end

  function void push8(logic [7:0] v);
    file_bytes.push_back(v);
  endfunction

  function void push16(logic [15:0] v);
    push8(v[7:0]);
    push8(v[15:8]);
  endfunction

  function void push32(logic [31:0] v);
    push16(v[15:0]);
    push16(v[31:16]);
  endfunction

  function void start_wav();
    file_bytes.delete();
    push32(TAG_RIFF);
    push32($urandom);
    push32(TAG_WAVE);
  endfunction

  function void push_fmt(logic [31:0] size, logic [15:0] ch, logic [31:0] rate,
                         logic [15:0] bits);
    push32(TAG_FMT);
    push32(size);
    push16($urandom_range(1) ? 16'd1 : 16'($urandom));
    push16(ch);
    push32(rate);
    push32($urandom);
    push16(16'($urandom));
    push16(bits);
    if (size > FMT_BODY_LEN) repeat (size - FMT_BODY_LEN) push8(8'($urandom));
  endfunction

  function void push_other_chunk(int unsigned size);
    logic [31:0] t;
    t = $urandom;
    if (t == TAG_FMT || t == TAG_DATA) t = t ^ 32'd1;
    push32(t);
    push32(size);
    repeat (size) push8(8'($urandom));
  endfunction

  function logic [15:0] sample_value();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_request(input logic fs, input logic [7:0] b);
    int unsigned gap;
    byte_valid <= 1'b1;
    file_start <= fs;
    data_byte <= b;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    tracker.take_byte(fs, b);
    gap = 0;
    while ($urandom_range(99) < send_idle) gap++;
    if (gap != 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_file(input bit mixed);
    logic fs;
    for (int i = 0; i < file_bytes.size(); i++) begin
      fs = (i == 0) || (mixed && $urandom_range(5) == 0);
      send_request(fs, file_bytes[i]);
    end
  endtask

  initial begin
    int unsigned mode, mode_bytes, pick, sel, eff, blen, j;
    bit          mixed, has_fmt;
    logic [15:0] ch, bits;
    logic [31:0] fsize, rate, dsize;
    tracker = new();
    rst <= 1'b1;
    byte_valid <= 1'b0;
    file_start <= 1'b0;
    data_byte <= 8'd0;
    result_ready <= 1'b0;
    send_idle = 11;
    recv_idle = 88;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    file_bytes.delete();
    push32(TAG_RIFF ^ 32'h0200_0000);
    push8(8'h00);
    push8(8'hFF);
    send_file(1'b0);

    file_bytes.delete();
    push32(TAG_RIFF);
    push32(32'hFFFF_FFFF);
    push32(TAG_WAVE ^ 32'h8000_0000);
    send_file(1'b0);

    start_wav();
    push32(TAG_DATA);
    push32(32'd4);
    push32(32'h1234_5678);
    send_file(1'b0);

    start_wav();
    push_fmt(32'd16, 16'd1, 32'd44100, 16'd8);
    push32(TAG_DATA);
    push32(32'd2);
    push16(16'd0);
    send_file(1'b0);

    start_wav();
    push_fmt(32'd16, 16'(MAX_CH + 1), 32'd48000, PCM_BITS);
    push32(TAG_DATA);
    push32(32'd18);
    push16(16'd1);
    send_file(1'b0);

    start_wav();
    push_fmt(32'd16, 16'hFFFF, 32'd8000, PCM_BITS);
    push32(TAG_DATA);
    push32(32'hFFFF_FFFF);
    push16(16'hFFFF);
    send_file(1'b0);

    // A zero channel count acts as one; the fmt size of zero still reads the full body.
    start_wav();
    push_fmt(32'd0, 16'd0, 32'd0, PCM_BITS);
    push32(TAG_DATA);
    push32(32'd5);
    push16(16'h7FFF);
    push16(16'h8000);
    push8(8'hAA);
    push8(8'h55);
    send_file(1'b0);

    start_wav();
    push_other_chunk(0);
    push_fmt(32'd20, 16'(MAX_CH), 32'hFFFF_FFFF, PCM_BITS);
    push_other_chunk(3);
    push32(TAG_DATA);
    push32(32'd32);
    repeat (MAX_CH) push16(16'h8000);
    repeat (MAX_CH) push16(16'h7FFF);
    send_file(1'b0);

    // The second fmt chunk replaces the first; odd sums must round toward zero.
    start_wav();
    push_fmt(32'd16, 16'd5, 32'd8000, 16'd8);
    push_fmt(32'd16, 16'd2, 32'd16000, PCM_BITS);
    push32(TAG_DATA);
    push32(32'd16);
    push16(16'hFFFD);
    push16(16'h0000);
    push16(16'h0003);
    push16(16'h0000);
    push16(16'h8000);
    push16(16'h8000);
    push16(16'h7FFF);
    push16(16'h8000);
    push8(8'h11);
    push8(8'h22);
    send_file(1'b0);

    start_wav();
    push_fmt(32'd16, 16'd2, 32'd11025, PCM_BITS);
    push32(TAG_DATA);
    push32(32'd3);
    repeat (5) push8(8'($urandom));
    send_file(1'b0);

    start_wav();
    push_fmt(32'd16, 16'd1, RATE_RESET, PCM_BITS);
    push32(TAG_DATA);
    push32(32'hFFFF_FFFE);
    repeat (3) push16(sample_value());
    send_file(1'b0);

    start_wav();
    push32(TAG_FMT);
    push8(8'h10);
    send_file(1'b0);

    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle = 11;
          recv_idle = 88;
        end
        1: begin
          send_idle = 88;
          recv_idle = 11;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      mode_bytes = 0;
      while (mode_bytes < 30) begin
        pick = $urandom_range(99);
        mixed = 1'b0;
        if (pick < 3) begin
          file_bytes.delete();
          repeat ($urandom_range(12, 4)) push8(8'($urandom));
          mixed = 1'b1;
        end else if (pick < 6) begin
          file_bytes.delete();
          push32(TAG_RIFF ^ (32'd1 << $urandom_range(31)));
          push32($urandom);
        end else if (pick < 9) begin
          file_bytes.delete();
          push32(TAG_RIFF);
          push32($urandom);
          push32(TAG_WAVE ^ (32'd1 << $urandom_range(31)));
        end else begin
          start_wav();
          repeat ($urandom_range(2)) push_other_chunk($urandom_range(5));
          sel = $urandom_range(19);
          ch = (sel == 0) ? 16'd0 :
               (sel == 1) ? 16'(MAX_CH + 1) :
               (sel == 2) ? 16'($urandom_range(65535, MAX_CH + 1)) :
                            16'($urandom_range(MAX_CH, 1));
          bits = ($urandom_range(11) == 0) ? 16'($urandom) : PCM_BITS;
          has_fmt = ($urandom_range(24) != 0);
          if (has_fmt) begin
            if ($urandom_range(9) == 0)
              push_fmt(32'd16, 16'($urandom), $urandom, 16'($urandom));
            sel = $urandom_range(9);
            fsize = (sel < 7) ? FMT_BODY_LEN :
                    (sel < 9) ? 32'($urandom_range(24, 17)) : 32'($urandom_range(15));
            rate = ($urandom_range(3) == 0) ? 32'd44100 : 32'($urandom);
            push_fmt(fsize, ch, rate, bits);
          end
          if ($urandom_range(3) == 0) push_other_chunk($urandom_range(5));
          eff = (ch == 16'd0) ? 1 : ch;
          sel = $urandom_range(19);
          if (sel == 0) dsize = $urandom_range(2 * eff - 1);
          else if (sel == 1) dsize = $urandom;
          else dsize = $urandom_range(5, 1) * 2 * eff + $urandom_range(3);
          push32(TAG_DATA);
          push32(dsize);
          blen = dsize;
          if (sel == 1 || !has_fmt || bits != PCM_BITS || eff > MAX_CH)
            blen = $urandom_range(6);
          for (j = 0; j + 1 < blen; j += 2) push16(sample_value());
          if (j < blen) push8(8'($urandom));
          if ($urandom_range(11) == 0)
            repeat ($urandom_range(file_bytes.size() - 1)) void'(file_bytes.pop_back());
        end
        mode_bytes += file_bytes.size();
        repeat ($urandom_range(3)) push8(8'($urandom));
        send_file(mixed);
      end
    end
    byte_valid <= 1'b0;

    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.pending.size() != 0) tracker.report("expected results never arrived");
    if (tracker.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
